/* sv/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types, codes and reset values for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // default width of the stored time values
  localparam int TIME_BITS_DEF = 32;

  // field widths
  localparam int TS_W    = 32;
  localparam int CMD_W   = 2;
  localparam int TYPE_W  = 2;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // event commands
  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // click types
  localparam logic [TYPE_W-1:0] TYPE_NONE   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_SINGLE = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_HOLD   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN   = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] SINGLE_MAX_RST = 16'd250;
  localparam logic [CFG_W-1:0] DOUBLE_MAX_RST = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_MIN_RST   = 16'd1000;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TS_W-1:0]  timestamp;
  } evt_t;

  // result item
  typedef struct packed {
    logic [TYPE_W-1:0] click_type;
    logic              pending;
  } res_t;

  // thresholds handed to the classifier
  typedef struct packed {
    logic [CFG_W-1:0] single_max;
    logic [CFG_W-1:0] double_max;
    logic [CFG_W-1:0] hold_min;
  } cfg_t;

endpackage

/* sv/bcc_core.sv */
// ----------------------------------------------------------------------------
// bcc_core
// Click state registers and the one-pass classification of each event.
// ----------------------------------------------------------------------------
module bcc_core #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [bcc_pkg::CMD_W-1:0]  cmd,
  input  logic [TIME_BITS-1:0]       t,
  input  bcc_pkg::cfg_t              cfg,
  output bcc_pkg::res_t              res_next
);
  import bcc_pkg::*;

  logic [TIME_BITS-1:0] press_start, press_start_next;
  logic [TIME_BITS-1:0] prev_start, prev_start_next;
  logic                 pending_flag, pending_flag_next;
  logic [TYPE_W-1:0]    last_type, last_type_next;

  logic [TIME_BITS-1:0] len;
  logic [TIME_BITS-1:0] since_prev;
  logic [TIME_BITS-1:0] single_max_w, double_max_w, hold_min_w;
  logic                 is_short, is_long, is_double;

  // thresholds widened to the time width
  assign single_max_w = TIME_BITS'(cfg.single_max);
  assign double_max_w = TIME_BITS'(cfg.double_max);
  assign hold_min_w   = TIME_BITS'(cfg.hold_min);

  // press length and span since previous press; negative, or no stored previous press, reads as zero
  assign len        = (t >= press_start) ? t - press_start : '0;
  assign since_prev = (prev_start == '0 || t < prev_start) ? '0 : t - prev_start;

  assign is_short  = (len <= single_max_w);
  assign is_long   = (len >= hold_min_w);
  assign is_double = (since_prev <= double_max_w);

  // next state for the event
  always_comb begin
    press_start_next  = press_start;
    prev_start_next   = prev_start;
    pending_flag_next = pending_flag;
    last_type_next    = last_type;
    case (cmd)
      CMD_PRESS: begin
        if (pending_flag) begin
          prev_start_next = press_start;
        end
        press_start_next = t;
      end
      CMD_RELEASE: begin
        if (!pending_flag) begin
          if (is_short) begin
            last_type_next    = TYPE_SINGLE;
            pending_flag_next = 1'b1;
          end else if (is_long) begin
            last_type_next    = TYPE_HOLD;
            pending_flag_next = 1'b0;
            press_start_next  = '0;
            prev_start_next   = '0;
          end
        end else begin
          if (is_double) begin
            last_type_next    = TYPE_DOUBLE;
            pending_flag_next = 1'b0;
            press_start_next  = '0;
            prev_start_next   = '0;
          end else if (is_short) begin
            last_type_next    = TYPE_SINGLE;
            pending_flag_next = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        press_start_next  = '0;
        prev_start_next   = '0;
        pending_flag_next = 1'b0;
        last_type_next    = TYPE_NONE;
      end
      default: begin
      end
    endcase
  end

  // result reports the state after the event
  assign res_next.click_type = last_type_next;
  assign res_next.pending    = pending_flag_next;

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      press_start  <= '0;
      prev_start   <= '0;
      pending_flag <= 1'b0;
      last_type    <= TYPE_NONE;
    end else if (step) begin
      press_start  <= press_start_next;
      prev_start   <= prev_start_next;
      pending_flag <= pending_flag_next;
      last_type    <= last_type_next;
    end
  end

  // a pending click is always a single click
  a_pending_single: assert property (@(posedge clk) disable iff (rst)
    pending_flag |-> last_type == TYPE_SINGLE)
    else $error("pending set without single type");

  // clear leaves nothing behind
  a_clear: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_CLEAR |=> !pending_flag && last_type == TYPE_NONE &&
      press_start == '0 && prev_start == '0)
    else $error("state not cleared");

  // double click drops the stored times
  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_RELEASE && pending_flag && is_double |=>
      last_type == TYPE_DOUBLE && press_start == '0 && prev_start == '0)
    else $error("double click did not clear times");

  // state only moves on a transfer
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(pending_flag) && $stable(last_type) && $stable(press_start))
    else $error("state changed without transfer");

endmodule

/* sv/button_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies timestamped press and release events into single, double and
// hold clicks, one result per event.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | per transfer
//  --------+----------------------------------+-----------+------------------
//  evt     | evt_valid evt_ready evt          | in        | cmd, timestamp
//  res     | res_valid res_ready res          | out       | click_type, pending
//  cfg     | cfg_valid cfg_ready cfg_index    | in        | one 16-bit register
//          | cfg_data                         |           |
//
// One event per cycle while the result register is empty or being taken; its
// result is registered in the cycle after. The classification is a single pass
// of subtracts and compares between the state registers and the result register.
// evt_ready is high whenever the result register is empty or being taken,
// so a stalled result stops new events only while it is held.
// cfg_ready is always high. Synchronous reset clears state and result valid,
// and loads the thresholds with their reset values.
module button_click_classifier #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_ready,
  input  bcc_pkg::evt_t                 evt,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bcc_pkg::res_t                 res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);
  import bcc_pkg::*;

  cfg_t                 cfg;
  res_t                 res_next;
  logic                 evt_xfer;
  logic [TIME_BITS-1:0] t;

  // handshakes
  assign evt_ready = !res_valid || res_ready;
  assign evt_xfer  = evt_valid && evt_ready;
  assign cfg_ready = 1'b1;

  // timestamp taken modulo the time width
  assign t = TIME_BITS'(evt.timestamp);

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_max <= SINGLE_MAX_RST;
      cfg.double_max <= DOUBLE_MAX_RST;
      cfg.hold_min   <= HOLD_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SINGLE_MAX: cfg.single_max <= cfg_data;
        REG_DOUBLE_MAX: cfg.double_max <= cfg_data;
        REG_HOLD_MIN:   cfg.hold_min   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // classifier state and next result
  bcc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (evt_xfer),
    .cmd      (evt.cmd),
    .t        (t),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (evt_xfer) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_xfer) begin
      res <= res_next;
    end
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !evt_xfer)
    else $error("result overwritten while stalled");

  // every event transfer produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    evt_xfer |=> res_valid)
    else $error("missing result after event");

  // a held result stays unchanged
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule
